// ----- sv/lpd_pkg.sv -----
package lpd_pkg;

    localparam int COORD_BITS = 16;
    localparam int TIMER_BITS = 11;

    localparam int DELAY_W  = 11;
    localparam int THRESH_W = 8;
    localparam int CFG_W    = (DELAY_W > THRESH_W) ? DELAY_W : THRESH_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD = 1'd1;

    localparam logic [DELAY_W-1:0]  DELAY_RESET  = DELAY_W'(500);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(20);

    localparam logic [1:0] CMD_PRESS   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_MOTION  = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    localparam logic [1:0] ST_NONE       = 2'd0;
    localparam logic [1:0] ST_COLLECTING = 2'd1;
    localparam logic [1:0] ST_RECOGNIZED = 2'd2;

    localparam logic [3:0] BUTTON_PRIMARY = 4'd1;

    localparam int IN_USER_W  = 3;
    localparam int IN_BITS    = 16 + 2 * COORD_BITS;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 4 + 2 * COORD_BITS;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [1:0]            cmd;
        logic                  is_touch;
        logic [3:0]            button;
        logic [3:0]            device_id;
        logic [7:0]            sequence_id;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } t_event;

    typedef struct packed {
        logic                  handled;
        logic                  fire_now;
        logic [COORD_BITS-1:0] press_x;
        logic [COORD_BITS-1:0] press_y;
        logic [1:0]            gesture_state;
    } t_result;

    typedef struct packed {
        logic [DELAY_W-1:0]  delay_ticks;
        logic [THRESH_W-1:0] move_threshold;
    } t_cfg;

    // countdown load: saturate to the timer range, never zero
    function automatic logic [TIMER_BITS-1:0] delay_load(input logic [DELAY_W-1:0] d);
        logic [DELAY_W+TIMER_BITS-1:0] dx;
        logic [DELAY_W+TIMER_BITS-1:0] tmax;
        logic [TIMER_BITS-1:0]         v;
        dx   = (DELAY_W+TIMER_BITS)'(d);
        tmax = (DELAY_W+TIMER_BITS)'({TIMER_BITS{1'b1}});
        if (dx > tmax) begin
            v = {TIMER_BITS{1'b1}};
        end else begin
            v = dx[TIMER_BITS-1:0];
        end
        if (v == '0) begin
            v = TIMER_BITS'(1);
        end
        return v;
    endfunction

endpackage

// ----- sv/lpd_cfg.sv -----
module lpd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lpd_pkg::CFG_W-1:0]       i_cfg_data,
    output lpd_pkg::t_cfg                   o_cfg
);
    import lpd_pkg::*;

    logic [DELAY_W-1:0]  r_delay;
    logic [THRESH_W-1:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= DELAY_RESET;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELAY_TICKS:    r_delay  <= i_cfg_data[DELAY_W-1:0];
                CFG_MOVE_THRESHOLD: r_thresh <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg.delay_ticks    = r_delay;
    assign o_cfg.move_threshold = r_thresh;

endmodule

// ----- sv/lpd_core.sv -----
module lpd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  lpd_pkg::t_event  i_event,
    input  lpd_pkg::t_cfg    i_cfg,
    output lpd_pkg::t_result o_result
);
    import lpd_pkg::*;

    logic                  r_owned;
    logic [3:0]            r_dev;
    logic [7:0]            r_seq;
    logic [COORD_BITS-1:0] r_sx;
    logic [COORD_BITS-1:0] r_sy;
    logic [TIMER_BITS-1:0] r_cd;
    logic                  r_fired;

    logic                  n_owned;
    logic [3:0]            n_dev;
    logic [7:0]            n_seq;
    logic [COORD_BITS-1:0] n_sx;
    logic [COORD_BITS-1:0] n_sy;
    logic [TIMER_BITS-1:0] n_cd;
    logic                  n_fired;

    logic is_owner;
    logic primary;
    logic free_for_us;
    logic moved;

    function automatic logic [COORD_BITS:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
        logic signed [COORD_BITS:0] d;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        return d[COORD_BITS] ? (COORD_BITS+1)'(-d) : (COORD_BITS+1)'(d);
    endfunction

    always_comb begin
        is_owner    = r_owned && (r_dev == i_event.device_id)
                      && (r_seq == i_event.sequence_id);
        primary     = i_event.is_touch || (i_event.button == BUTTON_PRIMARY);
        free_for_us = !r_owned || ((r_dev == i_event.device_id)
                      && ((r_seq == '0) || (r_seq == i_event.sequence_id)));
        moved       = (abs_diff(r_sx, i_event.pos_x) > (COORD_BITS+1)'(i_cfg.move_threshold))
                      || (abs_diff(r_sy, i_event.pos_y) > (COORD_BITS+1)'(i_cfg.move_threshold));

        n_owned = r_owned;
        n_dev   = r_dev;
        n_seq   = r_seq;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_cd    = r_cd;
        n_fired = r_fired;
        o_result = '0;

        unique case (i_event.cmd)
            CMD_PRESS: begin
                if (primary && free_for_us) begin
                    n_owned = 1'b1;
                    n_dev   = i_event.device_id;
                    n_seq   = i_event.sequence_id;
                    n_sx    = i_event.pos_x;
                    n_sy    = i_event.pos_y;
                    n_fired = 1'b0;
                    n_cd    = delay_load(i_cfg.delay_ticks);
                    o_result.handled = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (is_owner) begin
                    o_result.handled = r_fired;
                    n_owned = 1'b0;
                    n_cd    = '0;
                    n_fired = 1'b0;
                end
            end
            CMD_MOTION: begin
                if (is_owner && moved) begin
                    n_owned = 1'b0;
                    n_cd    = '0;
                    n_fired = 1'b0;
                end
            end
            CMD_TICK: begin
                if (r_owned && (r_cd != '0)) begin
                    n_cd = r_cd - TIMER_BITS'(1);
                    if (r_cd == TIMER_BITS'(1)) begin
                        n_fired = 1'b1;
                        o_result.fire_now = 1'b1;
                        o_result.press_x  = r_sx;
                        o_result.press_y  = r_sy;
                    end
                end
            end
            default: ;
        endcase

        if (!n_owned) begin
            o_result.gesture_state = ST_NONE;
        end else if (n_cd != '0) begin
            o_result.gesture_state = ST_COLLECTING;
        end else if (n_fired) begin
            o_result.gesture_state = ST_RECOGNIZED;
        end else begin
            o_result.gesture_state = ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owned <= 1'b0;
            r_cd    <= '0;
            r_fired <= 1'b0;
        end else if (i_step) begin
            r_owned <= n_owned;
            r_cd    <= n_cd;
            r_fired <= n_fired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_dev <= n_dev;
            r_seq <= n_seq;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
        end
    end

endmodule

// ----- sv/long_press_detector.sv -----
// path: input transfer into the input register, then the result register to the master side
// throughput: one event per cycle while the master side accepts results; the gesture step
// is combinational between the input register and the result register
// reset: synchronous active-low i_rst_n clears the gesture, the valid flags of
// both registers and loads delay_ticks 500 and move_threshold 20
module long_press_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lpd_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // button, device_id, sequence_id, pos_x, pos_y
    input  logic [lpd_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // cmd, is_touch
    input  logic [lpd_pkg::IN_USER_W-1:0]    i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // handled, fire_now, press_x, press_y, gesture_state, zero pad
    output logic [lpd_pkg::OUT_DATA_W-1:0]   o_m_tdata
);
    import lpd_pkg::*;

    logic    r_in_valid;
    t_event  r_in;
    t_event  in_event;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    t_cfg    cfg;
    logic    advance;

    lpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lpd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_event  (r_in),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    assign in_event.cmd         = i_s_tuser[1:0];
    assign in_event.is_touch    = i_s_tuser[2];
    assign in_event.button      = i_s_tdata[3:0];
    assign in_event.device_id   = i_s_tdata[7:4];
    assign in_event.sequence_id = i_s_tdata[15:8];
    assign in_event.pos_x       = i_s_tdata[16 +: COORD_BITS];
    assign in_event.pos_y       = i_s_tdata[16 + COORD_BITS +: COORD_BITS];

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in <= in_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out.gesture_state, r_out.press_y, r_out.press_x,
                                     r_out.fire_now, r_out.handled});

    // a fired long press always leaves the gesture recognized
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.fire_now) |-> (r_out.gesture_state == ST_RECOGNIZED))
        else $error("long press result without recognized state");

    // every step produces a result on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("step did not produce a result");

    // input side only stalls while an event is held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a held event");

endmodule

// ----- bench/testbench.sv -----
module testbench;
    import lpd_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_DATA_W-1:0]    i_s_tdata;
    logic [IN_USER_W-1:0]    i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_DATA_W-1:0]   o_m_tdata;

    long_press_detector u_dut (.*);

    // gesture model state
    logic [DELAY_W-1:0]          cfg_delay;
    logic [THRESH_W-1:0]         cfg_thresh;
    logic                        g_owned;
    logic [3:0]                  g_dev;
    logic [7:0]                  g_seq;
    logic signed [COORD_BITS-1:0] g_x;
    logic signed [COORD_BITS-1:0] g_y;
    logic [TIMER_BITS-1:0]       g_count;
    logic                        g_fired;

    t_result pending_results[$];
    int      errors;
    int      sent_count;
    bit      quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int idle_len();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 96) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic void free_gesture();
        g_owned = 1'b0;
        g_dev   = '0;
        g_seq   = '0;
        g_count = '0;
        g_fired = 1'b0;
    endfunction

    function automatic t_result predict_event(input t_event ev);
        t_result r;
        logic    is_owner;
        logic    primary;
        logic    claimable;
        int      dx;
        int      dy;
        r = '0;
        is_owner = g_owned && g_dev == ev.device_id && g_seq == ev.sequence_id;
        case (ev.cmd)
            CMD_PRESS: begin
                primary   = ev.is_touch || ev.button == BUTTON_PRIMARY;
                claimable = !g_owned || (g_dev == ev.device_id &&
                            (g_seq == 8'd0 || g_seq == ev.sequence_id));
                if (primary && claimable) begin
                    g_owned   = 1'b1;
                    g_dev     = ev.device_id;
                    g_seq     = ev.sequence_id;
                    g_x       = ev.pos_x;
                    g_y       = ev.pos_y;
                    g_fired   = 1'b0;
                    // delay and timer share a width, so only zero needs a fix
                    g_count   = (cfg_delay == '0) ? TIMER_BITS'(1) : TIMER_BITS'(cfg_delay);
                    r.handled = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (is_owner) begin
                    r.handled = g_fired;
                    free_gesture();
                end
            end
            CMD_MOTION: begin
                if (is_owner) begin
                    dx = $signed(g_x) - $signed(ev.pos_x);
                    dy = $signed(g_y) - $signed(ev.pos_y);
                    if (dx < 0) dx = -dx;
                    if (dy < 0) dy = -dy;
                    if (dx > int'(cfg_thresh) || dy > int'(cfg_thresh)) begin
                        free_gesture();
                    end
                end
            end
            default: begin
                if (g_owned && g_count != '0) begin
                    g_count = g_count - 1'b1;
                    if (g_count == '0) begin
                        g_fired    = 1'b1;
                        r.fire_now = 1'b1;
                        r.press_x  = g_x;
                        r.press_y  = g_y;
                    end
                end
            end
        endcase
        if (!g_owned) begin
            r.gesture_state = ST_NONE;
        end else if (g_count != '0) begin
            r.gesture_state = ST_COLLECTING;
        end else if (g_fired) begin
            r.gesture_state = ST_RECOGNIZED;
        end else begin
            r.gesture_state = ST_NONE;
        end
        return r;
    endfunction

    function automatic t_event make_event(input logic [1:0] cmd, input logic touch,
                                          input logic [3:0] btn, input logic [3:0] dev,
                                          input logic [7:0] seq,
                                          input logic [COORD_BITS-1:0] x,
                                          input logic [COORD_BITS-1:0] y);
        t_event ev;
        ev.cmd         = cmd;
        ev.is_touch    = touch;
        ev.button      = btn;
        ev.device_id   = dev;
        ev.sequence_id = seq;
        ev.pos_x       = x;
        ev.pos_y       = y;
        return ev;
    endfunction

    task automatic send_event(input t_event ev);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ev.pos_y, ev.pos_x, ev.sequence_id, ev.device_id, ev.button};
        i_s_tuser  <= {ev.is_touch, ev.cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(predict_event(ev));
        sent_count++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) begin
            send_event(make_event(CMD_TICK, 1'($urandom), 4'($urandom), 4'($urandom),
                                  8'($urandom), 16'($urandom), 16'($urandom)));
        end
    endtask

    task automatic send_noise();
        send_event(make_event(2'($urandom), 1'($urandom), 4'($urandom), 4'($urandom),
                              8'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [DELAY_W-1:0] d, input logic [THRESH_W-1:0] t);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DELAY_TICKS;
        i_cfg_data <= CFG_W'(d);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MOVE_THRESHOLD;
        // upper bits are dropped by the threshold register
        i_cfg_data <= {(CFG_W-THRESH_W)'($urandom), t};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_delay  = d;
        cfg_thresh = t;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // result side: tready stalls
    initial begin
        int stall;
        stall = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall == 0) stall = idle_len();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                stall--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.handled       = o_m_tdata[0];
            got.fire_now      = o_m_tdata[1];
            got.press_x       = o_m_tdata[2 +: COORD_BITS];
            got.press_y       = o_m_tdata[2+COORD_BITS +: COORD_BITS];
            got.gesture_state = o_m_tdata[2+2*COORD_BITS +: 2];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %0h",
                         $time, o_m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("handled", want.handled, got.handled);
                check_field("fire_now", want.fire_now, got.fire_now);
                check_field("press_x", want.press_x, got.press_x);
                check_field("press_y", want.press_y, got.press_y);
                check_field("gesture_state", want.gesture_state, got.gesture_state);
            end
        end
    end

    task automatic test_default_registers();
        send_event(make_event(CMD_PRESS, 1'b0, BUTTON_PRIMARY, 4'd2, 8'd0, 16'd100, -16'sd100));
        send_event(make_event(CMD_MOTION, 1'b0, 4'd0, 4'd2, 8'd0, 16'd120, -16'sd120));
        send_ticks(500);
        send_event(make_event(CMD_RELEASE, 1'b0, BUTTON_PRIMARY, 4'd2, 8'd0, 16'd0, 16'd0));
        send_event(make_event(CMD_PRESS, 1'b0, BUTTON_PRIMARY, 4'd2, 8'd0, 16'd0, 16'd0));
        send_event(make_event(CMD_MOTION, 1'b0, 4'd0, 4'd2, 8'd0, 16'd21, 16'd0));
        send_event(make_event(CMD_RELEASE, 1'b0, BUTTON_PRIMARY, 4'd2, 8'd0, 16'd0, 16'd0));
    endtask

    task automatic test_directed_cases();
        set_config(11'd2, 8'd20);
        send_event(make_event(CMD_PRESS, 1'b0, BUTTON_PRIMARY, 4'd15, 8'd0,
                              16'h7fff, 16'h8000));
        // other button, other device
        send_event(make_event(CMD_PRESS, 1'b0, 4'd2, 4'd15, 8'd0, 16'd1, 16'd1));
        send_event(make_event(CMD_PRESS, 1'b1, 4'd0, 4'd5, 8'd9, 16'd2, 16'd2));
        // same device takes over a gesture with no sequence
        send_event(make_event(CMD_PRESS, 1'b1, 4'd0, 4'd15, 8'd77, 16'd0, 16'd0));
        send_event(make_event(CMD_MOTION, 1'b0, 4'd0, 4'd15, 8'd0, 16'h4000, 16'h4000));
        send_event(make_event(CMD_MOTION, 1'b1, 4'd0, 4'd15, 8'd77, 16'd20, -16'sd20));
        send_ticks(3);
        send_event(make_event(CMD_RELEASE, 1'b1, 4'd15, 4'd15, 8'd77, 16'd0, 16'd0));
        send_event(make_event(CMD_RELEASE, 1'b0, BUTTON_PRIMARY, 4'd3, 8'd0, 16'd0, 16'd0));
        send_ticks(1);
        // device zero, press again by the owner
        send_event(make_event(CMD_PRESS, 1'b1, 4'd0, 4'd0, 8'd255, 16'h8000, 16'h7fff));
        send_event(make_event(CMD_PRESS, 1'b1, 4'd0, 4'd0, 8'd255, 16'd10, 16'd10));
        send_ticks(1);
        send_event(make_event(CMD_PRESS, 1'b1, 4'd0, 4'd0, 8'd255, 16'd10, 16'd10));
        send_ticks(2);
        // motion after firing
        send_event(make_event(CMD_MOTION, 1'b1, 4'd0, 4'd0, 8'd255, 16'd40, 16'd10));
        send_event(make_event(CMD_RELEASE, 1'b1, 4'd0, 4'd0, 8'd255, 16'd0, 16'd0));
        send_event(make_event(CMD_PRESS, 1'b0, BUTTON_PRIMARY, 4'd8, 8'd3, 16'd5, 16'd5));
        send_event(make_event(CMD_MOTION, 1'b0, 4'd0, 4'd8, 8'd3, 16'd5, 16'd26));
        send_event(make_event(CMD_RELEASE, 1'b0, BUTTON_PRIMARY, 4'd8, 8'd3, 16'd0, 16'd0));
    endtask

    task automatic test_register_extremes();
        set_config(11'd0, 8'd0);
        send_event(make_event(CMD_PRESS, 1'b1, 4'd0, 4'd1, 8'd1, 16'd0, 16'd0));
        send_event(make_event(CMD_MOTION, 1'b1, 4'd0, 4'd1, 8'd1, 16'd0, 16'd0));
        send_ticks(1);
        send_event(make_event(CMD_MOTION, 1'b1, 4'd0, 4'd1, 8'd1, 16'd1, 16'd0));
        send_event(make_event(CMD_RELEASE, 1'b1, 4'd0, 4'd1, 8'd1, 16'd0, 16'd0));
        send_event(make_event(CMD_PRESS, 1'b1, 4'd0, 4'd1, 8'd1, 16'd0, 16'd0));
        send_event(make_event(CMD_MOTION, 1'b1, 4'd0, 4'd1, 8'd1, 16'd0, 16'hffff));
        set_config(11'd2047, 8'd255);
        send_event(make_event(CMD_PRESS, 1'b0, BUTTON_PRIMARY, 4'd6, 8'd0, 16'h7f01, 16'd0));
        send_event(make_event(CMD_MOTION, 1'b0, 4'd0, 4'd6, 8'd0, 16'h7fff, 16'd255));
        send_ticks(40);
        send_event(make_event(CMD_RELEASE, 1'b0, 4'd9, 4'd6, 8'd0, 16'd0, 16'd0));
        // coordinate wrap gives a large distance
        send_event(make_event(CMD_PRESS, 1'b0, BUTTON_PRIMARY, 4'd6, 8'd0, 16'h7fff, 16'd0));
        send_event(make_event(CMD_MOTION, 1'b0, 4'd0, 4'd6, 8'd0, 16'h8000, 16'd0));
        send_event(make_event(CMD_RELEASE, 1'b0, BUTTON_PRIMARY, 4'd6, 8'd0, 16'd0, 16'd0));
    endtask

    task automatic run_gesture();
        logic [3:0]            dev;
        logic [7:0]            seq;
        logic                  touch;
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        int                    steps;
        int                    r;
        int                    lim;
        int                    ox;
        int                    oy;
        dev   = 4'($urandom);
        seq   = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom);
        touch = 1'($urandom);
        cx    = 16'($urandom);
        cy    = 16'($urandom);
        send_event(make_event(CMD_PRESS, touch, touch ? 4'($urandom) : BUTTON_PRIMARY,
                              dev, seq, cx, cy));
        steps = $urandom_range(1, int'(cfg_delay) + 6);
        repeat (steps) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_ticks(1);
            end else if (r < 80) begin
                lim = ($urandom_range(0, 9) == 0) ? int'(cfg_thresh) + 50 : int'(cfg_thresh) + 1;
                ox  = int'($urandom_range(0, 2 * lim)) - lim;
                oy  = int'($urandom_range(0, 2 * lim)) - lim;
                send_event(make_event(CMD_MOTION, touch, 4'($urandom), dev, seq,
                                      cx + 16'(ox), cy + 16'(oy)));
            end else if (r < 92) begin
                send_noise();
            end else if (r < 96) begin
                cx = cx + 16'($urandom_range(0, 7));
                send_event(make_event(CMD_PRESS, touch, touch ? 4'($urandom) : BUTTON_PRIMARY,
                                      dev, seq, cx, cy));
            end else begin
                send_event(make_event(CMD_RELEASE, 1'($urandom), 4'($urandom), 4'($urandom),
                                      8'($urandom), 16'($urandom), 16'($urandom)));
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            send_event(make_event(CMD_RELEASE, touch, 4'($urandom), dev, seq,
                                  16'($urandom), 16'($urandom)));
        end
    endtask

    task automatic test_random_gestures();
        logic [DELAY_W-1:0]  d;
        logic [THRESH_W-1:0] t;
        int                  target;
        for (int p = 0; p < 10; p++) begin
            case (p % 5)
                0:       d = 11'd0;
                1:       d = 11'($urandom_range(1, 4));
                2:       d = 11'($urandom_range(5, 12));
                3:       d = 11'd1;
                default: d = 11'($urandom_range(1, 8));
            endcase
            if (p == 1) begin
                t = 8'd0;
            end else if (p == 2) begin
                t = 8'd255;
            end else if ($urandom_range(0, 3) == 0) begin
                t = 8'($urandom);
            end else begin
                t = 8'($urandom_range(0, 40));
            end
            set_config(d, t);
            quiet  = (p == 3);
            target = sent_count + 90;
            while (sent_count < target) begin
                if ($urandom_range(0, 4) != 0) begin
                    run_gesture();
                end else begin
                    send_noise();
                end
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        cfg_delay  = DELAY_RESET;
        cfg_thresh = THRESH_RESET;
        g_x        = '0;
        g_y        = '0;
        free_gesture();
        errors     = 0;
        sent_count = 0;
        quiet      = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_registers();
        test_directed_cases();
        test_register_extremes();
        test_random_gestures();
        wait_idle();
        repeat (6) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/lpd_pkg.sv
sv/lpd_cfg.sv
sv/lpd_core.sv
sv/long_press_detector.sv
bench/testbench.sv
